FILE: src/assert_macros.svh
// Assertion macros shared by the RTL of the measurement scheduler.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is held.
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");
// Next-cycle implication, disabled while reset is held.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");
`else
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

FILE: src/hsms_pkg.sv
// Types, codes and constants of the humidity sensor measurement scheduler.
`default_nettype none
package hsms_pkg;

  localparam int TIME_W = 32;
  localparam int CFG_W  = 16;
  localparam int CFG_IDX_W = 1;

  typedef logic [TIME_W-1:0] time_t;
  typedef logic [CFG_W-1:0]  ms16_t;

  // Event opcodes
  localparam logic [2:0] OP_TICK       = 3'd0;
  localparam logic [2:0] OP_TRIGGER    = 3'd1;
  localparam logic [2:0] OP_DISABLE    = 3'd2;
  localparam logic [2:0] OP_SET_IVAL   = 3'd3;
  localparam logic [2:0] OP_WRITE_DONE = 3'd4;
  localparam logic [2:0] OP_READ_DONE  = 3'd5;

  // Bus requests
  localparam logic [1:0] ACT_NONE  = 2'd0;
  localparam logic [1:0] ACT_START = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RETRY_DELAY  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MEASURE_WAIT = 1'b1;

  localparam ms16_t RETRY_DELAY_RST  = 16'd2000;
  localparam ms16_t MEASURE_WAIT_RST = 16'd80;

  localparam logic [7:0] ERROR_MARK = 8'hFF;

  // Unsigned Q0.24 scale factors
  localparam int RAW_W   = 20;
  localparam int TEMP_KW = 19;
  localparam int HUM_KW  = 18;
  localparam logic [TEMP_KW-1:0] TEMP_K = 19'd320445;
  localparam logic [HUM_KW-1:0]  HUM_K  = 18'd159384;
  localparam int FRAC_W = 24;

  localparam logic signed [14:0] TEMP_OFFSET = 15'sd5000;
  localparam logic [13:0]        HUM_MAX     = 14'd10000;

  // Wrapping time comparison: true once delay ms have passed since 'since'
  function automatic logic elapsed(input time_t now, input time_t since, input ms16_t delay);
    time_t diff;
    diff = now - since;
    return diff >= TIME_W'(delay);
  endfunction

endpackage
`default_nettype wire

FILE: src/humidity_sensor_measure_scheduler.sv
// Measurement scheduler: event decode, phase sequencing and raw-data conversion.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one event per transfer: a 1 ms
//   tick, a manual trigger, disable-auto, set-interval, write done or read done,
//   with the six raw read bytes for read done. Every event yields exactly one
//   result on the output channel (out_valid / out_stall): the bus request to
//   issue, an optional measurement in hundredths and the busy / error status.
//   Configuration (cfg_wr_en, cfg_index, cfg_wdata) sets the retry delay
//   (index 0) and the measurement wait (index 1); write only while idle.
// Timing:
//   An event is registered in the input register and is decoded, with the
//   state update and the two constant multiplies, into the output register;
//   one event is taken every cycle while the output is not stalled. The
//   state feedback through the event decode sets that rate.
// Reset (rst_n low, synchronous): phase idle, all timestamps zero, auto
//   trigger off, retry delay 2000 ms, wait 80 ms, both channels empty.
// Stall: a stalled result holds; the input register still takes one more
//   event, after which in_stall rises until the result is taken.
`default_nettype none
module humidity_sensor_measure_scheduler (
  input  wire                                   clk,
  input  wire                                   rst_n,
  input  wire                                   cfg_wr_en,
  input  wire  [hsms_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire  [hsms_pkg::CFG_W-1:0]            cfg_wdata,
  input  wire                                   in_valid,
  output logic                                  in_stall,
  input  wire  [2:0]                            in_opcode,
  input  wire  [15:0]                           in_interval_ms,
  input  wire                                   in_keep_interval,
  input  wire                                   in_bus_ok,
  input  wire  [7:0]                            in_raw_status,
  input  wire  [7:0]                            in_raw_hum_high,
  input  wire  [7:0]                            in_raw_hum_mid,
  input  wire  [7:0]                            in_raw_shared,
  input  wire  [7:0]                            in_raw_temp_mid,
  input  wire  [7:0]                            in_raw_temp_low,
  output logic                                  out_valid,
  input  wire                                   out_stall,
  output logic [1:0]                            out_bus_action,
  output logic                                  out_result_valid,
  output logic signed [14:0]                    out_temperature_centi,
  output logic [13:0]                           out_humidity_centi,
  output logic                                  out_data_error,
  output logic                                  out_busy_res,
  output logic                                  out_in_error
);
  import hsms_pkg::*;
`include "assert_macros.svh"

  typedef enum logic [2:0] {PH_IDLE, PH_TRIG, PH_WAIT, PH_READ, PH_ERR} phase_t;

  // Configuration
  ms16_t retry_delay_r, measure_wait_r;

  // Scheduler state
  phase_t phase_r, phase_nxt;
  time_t  now_r, now_nxt;
  time_t  action_time_r, action_time_nxt;
  time_t  last_meas_r, last_meas_nxt;
  time_t  retry_mark_r, retry_mark_nxt;
  ms16_t  interval_r, interval_nxt;

  // Input register
  logic        in_valid_r;
  logic [2:0]  opcode_r;
  ms16_t       ival_r;
  logic        keep_r, ok_r;
  logic [7:0]  status_r, hum_high_r, hum_mid_r, shared_r, temp_mid_r, temp_low_r;

  // Output register
  logic              out_valid_r;
  logic [1:0]        act_r, act_nxt;
  logic              rvalid_r, rvalid_nxt;
  logic signed [14:0] temp_r, temp_nxt;
  logic [13:0]       hum_r, hum_nxt;
  logic              derr_r, derr_nxt;
  logic              busy_r, err_r;

  logic exec;
  logic in_take;

  // Conversion datapath
  logic [RAW_W-1:0]           raw_t, raw_h;
  logic [RAW_W+TEMP_KW-1:0]   t_prod;
  logic [RAW_W+HUM_KW-1:0]    h_prod;
  logic [14:0]                t_scaled;
  logic [13:0]                h_scaled;

  assign exec     = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !exec;
  assign in_take  = in_valid && !in_stall;

  assign raw_t  = {shared_r[3:0], temp_mid_r, temp_low_r};
  assign raw_h  = {hum_high_r, hum_mid_r, shared_r[7:4]};
  assign t_prod = (RAW_W+TEMP_KW)'(raw_t) * (RAW_W+TEMP_KW)'(TEMP_K)
                  + ((RAW_W+TEMP_KW)'(1) << (FRAC_W-1));
  assign h_prod = (RAW_W+HUM_KW)'(raw_h) * (RAW_W+HUM_KW)'(HUM_K)
                  + ((RAW_W+HUM_KW)'(1) << (FRAC_W-1));
  assign t_scaled = t_prod[FRAC_W+14:FRAC_W];
  assign h_scaled = h_prod[FRAC_W+13:FRAC_W];

  always_comb begin
    phase_nxt       = phase_r;
    now_nxt         = now_r;
    action_time_nxt = action_time_r;
    last_meas_nxt   = last_meas_r;
    retry_mark_nxt  = retry_mark_r;
    interval_nxt    = interval_r;
    act_nxt         = ACT_NONE;
    rvalid_nxt      = 1'b0;
    derr_nxt        = 1'b0;
    temp_nxt        = '0;
    hum_nxt         = '0;
    case (opcode_r)
      OP_TICK: begin
        now_nxt = now_r + TIME_W'(1);
        if (phase_r == PH_ERR) begin
          if (elapsed(now_nxt, retry_mark_r, retry_delay_r)) begin
            phase_nxt      = PH_IDLE;
            retry_mark_nxt = now_nxt;
          end
        end else if (phase_r == PH_TRIG) begin
          phase_nxt       = PH_WAIT;
          action_time_nxt = now_nxt;
        end else begin
          if (phase_r == PH_WAIT && elapsed(now_nxt, action_time_r, measure_wait_r)) begin
            phase_nxt = PH_READ;
            act_nxt   = ACT_READ;
          end
          // auto trigger only from idle, after the wait check above
          if (interval_r != '0 && phase_r == PH_IDLE &&
              elapsed(now_nxt, last_meas_r, interval_r)) begin
            phase_nxt       = PH_TRIG;
            action_time_nxt = now_nxt;
            act_nxt         = ACT_START;
          end
        end
      end
      OP_TRIGGER: begin
        if (!keep_r) interval_nxt = ival_r;
        phase_nxt       = PH_TRIG;
        action_time_nxt = now_r;
        act_nxt         = ACT_START;
      end
      OP_DISABLE: begin
        interval_nxt = '0;
        phase_nxt    = PH_IDLE;
      end
      OP_SET_IVAL: begin
        if (!keep_r) interval_nxt = ival_r;
      end
      OP_WRITE_DONE: begin
        if (!ok_r && (phase_r == PH_TRIG || phase_r == PH_WAIT)) phase_nxt = PH_ERR;
      end
      OP_READ_DONE: begin
        if (phase_r == PH_READ) begin
          if (ok_r) begin
            rvalid_nxt = 1'b1;
            if (status_r == ERROR_MARK) begin
              derr_nxt = 1'b1;
            end else begin
              temp_nxt = $signed(t_scaled) - TEMP_OFFSET;
              hum_nxt  = (h_scaled > HUM_MAX) ? HUM_MAX : h_scaled;
            end
            last_meas_nxt = now_r;
            phase_nxt     = PH_IDLE;
          end else begin
            phase_nxt = PH_ERR;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      retry_delay_r  <= RETRY_DELAY_RST;
      measure_wait_r <= MEASURE_WAIT_RST;
      phase_r        <= PH_IDLE;
      now_r          <= '0;
      action_time_r  <= '0;
      last_meas_r    <= '0;
      retry_mark_r   <= '0;
      interval_r     <= '0;
      in_valid_r     <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_RETRY_DELAY:  retry_delay_r  <= cfg_wdata;
          REG_MEASURE_WAIT: measure_wait_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (in_take) begin
        in_valid_r <= 1'b1;
      end else if (exec) begin
        in_valid_r <= 1'b0;
      end
      if (exec) begin
        phase_r       <= phase_nxt;
        now_r         <= now_nxt;
        action_time_r <= action_time_nxt;
        last_meas_r   <= last_meas_nxt;
        retry_mark_r  <= retry_mark_nxt;
        interval_r    <= interval_nxt;
        out_valid_r   <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
    // payload: hold until the next transfer
    if (in_take) begin
      opcode_r   <= in_opcode;
      ival_r     <= in_interval_ms;
      keep_r     <= in_keep_interval;
      ok_r       <= in_bus_ok;
      status_r   <= in_raw_status;
      hum_high_r <= in_raw_hum_high;
      hum_mid_r  <= in_raw_hum_mid;
      shared_r   <= in_raw_shared;
      temp_mid_r <= in_raw_temp_mid;
      temp_low_r <= in_raw_temp_low;
    end
    if (exec) begin
      act_r    <= act_nxt;
      rvalid_r <= rvalid_nxt;
      temp_r   <= temp_nxt;
      hum_r    <= hum_nxt;
      derr_r   <= derr_nxt;
      busy_r   <= (phase_nxt != PH_IDLE);
      err_r    <= (phase_nxt == PH_ERR);
    end
  end

  assign out_valid             = out_valid_r;
  assign out_bus_action        = act_r;
  assign out_result_valid      = rvalid_r;
  assign out_temperature_centi = temp_r;
  assign out_humidity_centi    = hum_r;
  assign out_data_error        = derr_r;
  assign out_busy_res          = busy_r;
  assign out_in_error          = err_r;

  `ASSERT_IMPLIES(a_hum_clamped, clk, rst_n, out_valid_r, hum_r <= HUM_MAX)
  `ASSERT_IMPLIES(a_err_is_busy, clk, rst_n, out_valid_r && err_r, busy_r)
  `ASSERT_IMPLIES(a_meas_idle, clk, rst_n, out_valid_r && rvalid_r, act_r == ACT_NONE && !busy_r)
  `ASSERT_NEXT(a_err_tracks_phase, clk, rst_n, exec, err_r == (phase_r == PH_ERR))
  `ASSERT_NEXT(a_busy_tracks_phase, clk, rst_n, exec, busy_r == (phase_r != PH_IDLE))

endmodule
`default_nettype wire
